FILE: hdl/sha_pkg.sv
// Shared constants, types and helper functions for the SHA-256 engine.
// No dependencies; sha_buf, sha_core and the engine top in this folder import this package.
`timescale 1ns / 1ps
package sha_pkg;

   localparam int WORD_W = 32;
   localparam int BUF_DEPTH = 16;
   localparam int BUF_AW = $clog2(BUF_DEPTH);
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;

   localparam logic [WORD_W-1:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [WORD_W-1:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic start;
      logic clear;
   } core_ctl_type;

   function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                               input int n);
      rotr = (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic logic [WORD_W-1:0] sig0(input logic [WORD_W-1:0] x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [WORD_W-1:0] sig1(input logic [WORD_W-1:0] x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

FILE: hdl/sha_req_if.sv
// Input channel: one message byte per transfer with valid and last flags.
// Depends on nothing.
`timescale 1ns / 1ps
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last_byte;
   modport source (output valid, data_byte, byte_valid, last_byte, input ready);
   modport sink (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

FILE: hdl/sha_rsp_if.sv
// Result channel: one digest word per transfer.
// Depends on nothing.
`timescale 1ns / 1ps
interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: hdl/sha_buf.sv
// Block buffer memory: 16 words, one write and one registered read port.
// Uses sha_pkg for widths.
`timescale 1ns / 1ps
module sha_buf
   import sha_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [BUF_AW-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic [BUF_AW-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);
   logic [WORD_W-1:0] mem [BUF_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/sha_core.sv
// Compression core: one round per cycle, schedule window in registers,
// hash words held here. Reads block words from sha_buf. Uses sha_pkg.
`timescale 1ns / 1ps
module sha_core
   import sha_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  core_ctl_type      ctl,
   input  logic [WORD_W-1:0] rd_data,
   output logic [BUF_AW-1:0] rd_addr,
   input  logic [2:0]        sel,
   output logic [WORD_W-1:0] sel_word,
   output logic              busy
);
   typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} core_state_type;

   core_state_type    state_ff, state_in;
   logic [5:0]        rnd_ff, rnd_in;
   logic [WORD_W-1:0] hash_ff [8];
   logic [WORD_W-1:0] hash_in [8];
   logic [WORD_W-1:0] v_ff [8];
   logic [WORD_W-1:0] v_in [8];
   logic [WORD_W-1:0] win_ff [BUF_DEPTH];
   logic [WORD_W-1:0] win_in [BUF_DEPTH];
   logic [WORD_W-1:0] w_cur, t1, t2, sched;

   // win_ff[0] holds the newest schedule word.
   assign sched = win_ff[15] + sig0(win_ff[14]) + win_ff[6] + sig1(win_ff[1]);
   assign w_cur = (rnd_ff < 6'(BUF_DEPTH)) ? rd_data : sched;
   assign t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + ROUND_K[rnd_ff] + w_cur;
   assign t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   // The read for round r+1 is issued during round r; word 0 during start.
   assign rd_addr  = (state_ff == C_ROUND) ? rnd_ff[BUF_AW-1:0] + 1'b1 : '0;
   assign sel_word = hash_ff[sel];
   assign busy     = (state_ff != C_IDLE);

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      hash_in  = hash_ff;
      v_in     = v_ff;
      win_in   = win_ff;
      case (state_ff)
         C_IDLE: begin
            if (ctl.clear) begin
               hash_in = INIT_HASH;
            end
            if (ctl.start) begin
               v_in     = hash_ff;
               rnd_in   = '0;
               state_in = C_ROUND;
            end
         end
         C_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int k = BUF_DEPTH - 1; k > 0; k--) begin
               win_in[k] = win_ff[k-1];
            end
            win_in[0] = w_cur;
            rnd_in = rnd_ff + 1'b1;
            if (rnd_ff == 6'd63) begin
               state_in = C_ADD;
            end
         end
         C_ADD: begin
            for (int k = 0; k < 8; k++) begin
               hash_in[k] = hash_ff[k] + v_ff[k];
            end
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         rnd_ff   <= '0;
         hash_ff  <= INIT_HASH;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         hash_ff  <= hash_in;
      end
      v_ff   <= v_in;
      win_ff <= win_in;
   end
endmodule

FILE: hdl/sha256_hash_engine_unit.sv
// SHA-256 engine top level: byte packing, padding sequencer, digest output.
// A message byte is accepted only in the idle state; a full block then waits for compression.
// A last item pads one byte a cycle, except while a full block is compressed, with a second block
// when needed, then emits eight words, one a cycle when the sink is ready.
// Synchronous reset restores the initial hash values and clears counters; the
// block buffer memory is not cleared, it is always written before it is read.
`timescale 1ns / 1ps
module sha256_hash_engine_unit
   import sha_pkg::*;
(
   input logic     clock,
   input logic     reset,
   sha_req_if.sink req_chan,
   sha_rsp_if.source rsp_chan
);
   typedef enum logic [2:0] {
      S_IDLE, S_PAD80, S_PADZ, S_PADLEN, S_WAITC, S_EMIT
   } top_state_type;

   top_state_type     state_ff, state_in, resume_ff, resume_in;
   logic [5:0]        fill_ff, fill_in;
   logic [23:0]       word_ff, word_in;
   logic [63:0]       bits_ff, bits_in;
   logic [2:0]        idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic [2:0]        rsp_idx_ff, rsp_idx_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              push_en;
   logic [7:0]        push_byte;
   logic              wr_en;
   logic [BUF_AW-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data, sel_word;
   logic              core_busy;
   core_ctl_type      ctl;
   logic              req_xfer, block_full;
   top_state_type     after_push;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign block_full = push_en && (fill_ff == 6'd63);
   assign wr_en = push_en && (fill_ff[1:0] == 2'd3);

   sha_buf u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[5:2]),
      .wr_data ({word_ff, push_byte}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sha_core u_core (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .rd_data  (rd_data),
      .rd_addr  (rd_addr),
      .sel      (idx_ff),
      .sel_word (sel_word),
      .busy     (core_busy)
   );

   always_comb begin
      state_in     = state_ff;
      resume_in    = resume_ff;
      bits_in      = bits_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      push_en      = 1'b0;
      push_byte    = '0;
      after_push   = state_ff;
      ctl          = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               push_en   = req_chan.byte_valid;
               push_byte = req_chan.data_byte;
               if (req_chan.byte_valid) begin
                  bits_in = bits_ff + 64'd8;
               end
               after_push = req_chan.last_byte ? S_PAD80 : S_IDLE;
               state_in   = after_push;
            end
         end
         S_PAD80: begin
            push_en    = 1'b1;
            push_byte  = PAD_BYTE;
            after_push = S_PADZ;
            state_in   = after_push;
         end
         S_PADZ: begin
            if (fill_ff == LEN_START) begin
               idx_in   = '0;
               state_in = S_PADLEN;
            end else begin
               push_en    = 1'b1;
               after_push = S_PADZ;
            end
         end
         S_PADLEN: begin
            push_en   = 1'b1;
            push_byte = bits_ff[8 * (3'd7 - idx_ff) +: 8];
            idx_in    = idx_ff + 1'b1;
            // The eighth length byte always completes the block.
            after_push = S_EMIT;
         end
         S_WAITC: begin
            if (!core_busy) begin
               idx_in   = '0;
               state_in = resume_ff;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = sel_word;
               rsp_idx_in   = idx_ff;
               rsp_last_in  = (idx_ff == 3'd7);
               idx_in       = idx_ff + 1'b1;
               if (idx_ff == 3'd7) begin
                  ctl.clear = 1'b1;
                  bits_in   = '0;
                  state_in  = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (block_full) begin
         ctl.start = 1'b1;
         resume_in = after_push;
         state_in  = S_WAITC;
      end
   end

   assign fill_in = push_en ? fill_ff + 1'b1 : fill_ff;
   assign word_in = push_en ? {word_ff[15:0], push_byte} : word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         resume_ff    <= S_IDLE;
         fill_ff      <= '0;
         bits_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resume_ff    <= resume_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff     <= word_in;
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.digest_word = rsp_word_ff;
   assign rsp_chan.word_index  = rsp_idx_ff;
   assign rsp_chan.last_word   = rsp_last_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !core_busy) else $error("compression started while busy");
   a_req_core_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> !core_busy) else $error("byte taken during compression");
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_idx_ff == 3'd7)))
      else $error("last flag does not match word index");
   a_start_full: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> fill_ff == 6'd0) else $error("block started without full buffer");
endmodule

FILE: bench/sha256_hash_engine_checker.sv
// Checker for the SHA-256 engine: predicts digests from accepted byte transfers
// and compares each digest word transfer. Depends on sha_pkg and the channel interfaces.
`timescale 1ns / 1ps
module sha256_hash_engine_checker
   import sha_pkg::*;
(
   input logic      clock,
   input logic      reset,
   sha_req_if       req_chan,
   sha_rsp_if       rsp_chan,
   output int       fail_count,
   output int       words_pending
);

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_word_type;

   logic [31:0]     chain_value [8];
   logic [31:0]     msg_block [16];
   int unsigned     block_fill;
   logic [63:0]     bit_length;
   digest_word_type digest_queue [$];

   assign words_pending = digest_queue.size();

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, e, a;
      for (int i = 0; i < 16; i++) w[i] = msg_block[i];
      for (int i = 16; i < 64; i++) begin
         w[i] = w[i-16] + w[i-7]
              + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
              + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
      end
      for (int i = 0; i < 8; i++) v[i] = chain_value[i];
      for (int i = 0; i < 64; i++) begin
         a = v[0];
         e = v[4];
         t1 = v[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
            + ((e & v[5]) ^ (~e & v[6])) + ROUND_K[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
            + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_value[i] += v[i];
   endtask

   task automatic append_byte(input logic [7:0] b);
      msg_block[block_fill / 4][24 - 8 * (block_fill % 4) +: 8] = b;
      block_fill++;
      if (block_fill == 64) begin
         compress_block();
         block_fill = 0;
      end
   endtask

   task automatic restart_message();
      for (int i = 0; i < 8; i++) chain_value[i] = INIT_HASH[i];
      block_fill = 0;
      bit_length = '0;
   endtask

   task automatic absorb_transfer(input logic [7:0] b, input logic vld, input logic lst);
      logic [63:0] len;
      if (vld) begin
         bit_length += 64'd8;
         append_byte(b);
      end
      if (lst) begin
         len = bit_length;
         append_byte(PAD_BYTE);
         while (block_fill != 56) append_byte(8'h00);
         for (int i = 0; i < 8; i++) append_byte(len[56 - 8 * i +: 8]);
         for (int i = 0; i < 8; i++)
            digest_queue.push_back('{chain_value[i], 3'(i), i == 7});
         restart_message();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      restart_message();
   end

   always @(posedge clock) begin
      digest_word_type want;
      if (reset) begin
         restart_message();
      end else begin
         if (req_chan.valid && req_chan.ready)
            absorb_transfer(req_chan.data_byte, req_chan.byte_valid, req_chan.last_byte);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (digest_queue.size() == 0) begin
               report_mismatch("unexpected digest word", rsp_chan.digest_word, '0);
            end else begin
               want = digest_queue.pop_front();
               if (rsp_chan.digest_word !== want.digest_word)
                  report_mismatch("digest_word", rsp_chan.digest_word, want.digest_word);
               if (rsp_chan.word_index !== want.word_index)
                  report_mismatch("word_index", rsp_chan.word_index, want.word_index);
               if (rsp_chan.last_word !== want.last_word)
                  report_mismatch("last_word", rsp_chan.last_word, want.last_word);
            end
         end
      end
   end

endmodule

FILE: bench/tb.sv
// Top of the SHA-256 engine bench: clock, reset, byte stimulus and the verdict.
// Depends on sha_pkg, the channel interfaces, the engine and its checker.
`timescale 1ns / 1ps
module tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   words_pending;
   int   items_sent;
   bit   stall_free;

   sha_req_if req_chan ();
   sha_rsp_if rsp_chan ();

   sha256_hash_engine_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sha256_hash_engine_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   always #5 clock = ~clock;

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   // Digest word sink: random stalls, with stall-free stretches.
   initial begin
      int hold;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         hold = stall_free ? 0 : $urandom_range(0, 7);
         if (hold != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic vld, input logic lst);
      int gap;
      gap = stall_free ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= b;
      req_chan.byte_valid <= vld;
      req_chan.last_byte  <= lst;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_message(input int len, input logic [7:0] fill, input bit rand_bytes,
                               input bit last_carries_byte);
      for (int i = 0; i < len - (last_carries_byte ? 1 : 0); i++)
         send_byte(rand_bytes ? 8'($urandom) : fill, 1'b1, 1'b0);
      send_byte(rand_bytes ? 8'($urandom) : fill, last_carries_byte, 1'b1);
   endtask

   initial begin
      int len;
      items_sent = 0;
      stall_free = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      req_chan.byte_valid = 1'b0;
      req_chan.last_byte = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty message, a lone byte at each extreme, a byte ignored without last.
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'hff, 1'b1, 1'b1);
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'h5a, 1'b0, 1'b0);
      send_byte(8'ha5, 1'b0, 1'b1);
      // Fifty-five bytes: padding still fits in the same block.
      send_message(55, 8'h61, 1'b0, 1'b1);
      // Wait for the digest to drain before going on.
      req_chan.valid <= 1'b0;
      wait (words_pending == 0);
      repeat (4) @(negedge clock);

      // Random messages: mostly short, some across the block and padding boundaries.
      while (items_sent < 220) begin
         stall_free = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0: len = $urandom_range(54, 57);
            1: len = $urandom_range(62, 66);
            2: len = 0;
            default: len = $urandom_range(1, 12);
         endcase
         if ($urandom_range(0, 4) == 0)
            send_byte(8'($urandom), 1'b0, 1'b0);
         if (len == 0)
            send_byte(8'($urandom), 1'b0, 1'b1);
         else
            send_message(len, 8'h00, 1'b1, $urandom_range(0, 1));
      end
      stall_free = 1'b0;
      req_chan.valid <= 1'b0;

      wait (words_pending == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: sim.f
hdl/sha_pkg.sv
hdl/sha_req_if.sv
hdl/sha_rsp_if.sv
hdl/sha_buf.sv
hdl/sha_core.sv
hdl/sha256_hash_engine_unit.sv
bench/sha256_hash_engine_checker.sv
bench/tb.sv
